>>> src/u16f_pkg.sv
// ----------------------------------------------------------------------------
// u16f_pkg
// Shared codes, register offsets and constants of the 16550-style UART core
// ----------------------------------------------------------------------------
package u16f_pkg;

  // item codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_RX    = 2'd3;

  // register offsets
  localparam logic [2:0] REG_RBR = 3'd0;
  localparam logic [2:0] REG_IER = 3'd1;
  localparam logic [2:0] REG_IIR = 3'd2;
  localparam logic [2:0] REG_LCR = 3'd3;
  localparam logic [2:0] REG_MCR = 3'd4;
  localparam logic [2:0] REG_LSR = 3'd5;
  localparam logic [2:0] REG_MSR = 3'd6;
  localparam logic [2:0] REG_SCR = 3'd7;

  // interrupt identification codes
  localparam logic [7:0] IIR_NONE     = 8'h01;
  localparam logic [7:0] IIR_THRE     = 8'h02;
  localparam logic [7:0] IIR_RX_LEVEL = 8'h04;
  localparam logic [7:0] IIR_TIMEOUT  = 8'h0C;
  localparam logic [7:0] IIR_FIFO_ON  = 8'hC0;
  localparam logic [7:0] MSR_VALUE    = 8'hB0;

  localparam logic [4:0] TX_FULL = 5'd17;

  // character time = floor(div * 2097917 / 46080), 46080 = 1024 * 45
  localparam int          CT_W        = 22;
  localparam logic [21:0] CT_SCALE    = 22'd2097917;
  localparam int          CT_SHIFT    = 10;
  localparam logic [27:0] CT_RECIP    = 28'd190887436;
  localparam int          CT_RSHIFT   = 33;

  localparam logic [4:0] RX_TRIG [4] = '{5'd1, 5'd4, 5'd8, 5'd14};

  typedef logic [CT_W-1:0] char_time_t;

  function automatic logic [4:0] rx_trigger(input logic [7:0] fcr);
    logic [4:0] lvl;
    lvl = fcr[0] ? RX_TRIG[fcr[7:6]] : 5'd1;
    return lvl;
  endfunction

endpackage

>>> src/u16f_char_time.sv
// ----------------------------------------------------------------------------
// u16f_char_time
// Three-stage pipeline turning the divisor latch into a character time
// ----------------------------------------------------------------------------
module u16f_char_time (
  input  logic                   clk,
  input  logic [7:0]             dll,
  input  logic [7:0]             dlm,
  output u16f_pkg::char_time_t   char_time
);
  import u16f_pkg::*;

  logic [15:0] div;
  logic [37:0] prod_r;
  logic [27:0] quot;
  logic [39:0] ph_r;
  logic [43:0] pl_r;
  logic [54:0] sum;
  char_time_t  ct_r;

  always_comb begin
    div = {dlm, dll};
    if (div == 16'd0) begin
      div = 16'd1;
    end
    quot = prod_r[CT_SHIFT +: 28];
    sum  = 55'({ph_r, 16'd0}) + 55'(pl_r);
  end

  always_ff @(posedge clk) begin
    prod_r <= 38'(div) * 38'(CT_SCALE);
    ph_r   <= 40'(quot[27:16]) * 40'(CT_RECIP);
    pl_r   <= 44'(quot[15:0]) * 44'(CT_RECIP);
    ct_r   <= sum[CT_RSHIFT +: CT_W];
  end

  assign char_time = ct_r;

endmodule

>>> src/uart_16550_fifo_core_unit.sv
// ----------------------------------------------------------------------------
// uart_16550_fifo_core_unit
// 16550-style UART register model with receive FIFO and transmit timing
// ----------------------------------------------------------------------------
// Takes one item (tick, register read, register write or received byte) per
// clock and returns one result for it in the cycle after the transfer. A new
// item can follow in every cycle as long as the result side takes each result.
// A waiting result holds off the input. The interrupt line is decoded from the
// registered state, which always matches the result on offer. The character
// time comes from a three-stage pipeline (divisor multiply, reciprocal multiply
// split in two halves, sum). After reset, and after every write to the divisor
// latch, the input is held off while that pipeline settles. The result of a
// divisor latch write is also held back until then. The receive FIFO is a
// 16-entry memory with one write port and one read port.
module uart_16550_fifo_core_unit #(
  parameter int RX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [2:0] in_reg_req,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_irq,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_data
);
  import u16f_pkg::*;

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);

  logic [7:0]       dll_r, dll_nxt, dlm_r, dlm_nxt, lcr_r, lcr_nxt;
  logic [7:0]       mcr_r, mcr_nxt, scr_r, scr_nxt, fcr_r, fcr_nxt;
  logic [3:0]       ier_r, ier_nxt;
  logic [RX_AW-1:0] rx_head_r, rx_head_nxt;
  logic [RX_CW-1:0] rx_count_r, rx_count_nxt;
  logic [4:0]       tx_count_r, tx_count_nxt;
  logic             thre_r, thre_nxt;
  logic [47:0]      cc_r, cc_nxt, tx_due_r, tx_due_nxt, rx_moved_r, rx_moved_nxt;
  logic [1:0]       busy_r;

  logic [7:0]       rx_mem [RX_DEPTH];
  logic [RX_AW-1:0] rx_wr_addr;

  logic             out_valid_r, rd_sel_mem_r, tx_valid_r;
  logic [7:0]       rd_mem_r, rd_reg_r, tx_data_r;

  char_time_t       char_time;
  logic             in_acc, dlab, div_write, rx_push;
  logic             level_cur, timeout_cur;
  logic [48:0]      deadline;
  logic [47:0]      cc_inc;
  logic [7:0]       fifo_bits, rd_val;
  logic             rd_mem_sel, txv;

  u16f_char_time u_char_time (
    .clk       (clk),
    .dll       (dll_r),
    .dlm       (dlm_r),
    .char_time (char_time)
  );

  assign in_ready   = (busy_r == 2'd0) && (!out_valid_r || out_ready);
  assign in_acc     = in_valid && in_ready;
  assign dlab       = lcr_r[7];
  assign div_write  = (in_op == OP_WRITE) && dlab &&
                      ((in_reg_req == REG_RBR) || (in_reg_req == REG_IER));
  assign rx_push    = (in_op == OP_RX) && (rx_count_r != RX_CW'(RX_DEPTH));
  assign rx_wr_addr = rx_head_r + rx_count_r[RX_AW-1:0];
  assign deadline   = {1'b0, rx_moved_r} + {25'd0, char_time, 2'b00};
  assign cc_inc     = cc_r + 48'd1;
  assign fifo_bits  = fcr_r[0] ? IIR_FIFO_ON : 8'h00;
  assign level_cur  = rx_count_r >= RX_CW'(rx_trigger(fcr_r));
  assign timeout_cur = (rx_count_r != '0) && ({1'b0, cc_r} >= deadline);

  always_comb begin
    dll_nxt      = dll_r;
    dlm_nxt      = dlm_r;
    lcr_nxt      = lcr_r;
    mcr_nxt      = mcr_r;
    scr_nxt      = scr_r;
    fcr_nxt      = fcr_r;
    ier_nxt      = ier_r;
    rx_head_nxt  = rx_head_r;
    rx_count_nxt = rx_count_r;
    tx_count_nxt = tx_count_r;
    thre_nxt     = thre_r;
    cc_nxt       = cc_r;
    tx_due_nxt   = tx_due_r;
    rx_moved_nxt = rx_moved_r;
    rd_val       = 8'h00;
    rd_mem_sel   = 1'b0;
    txv          = 1'b0;
    case (in_op)
      OP_TICK: begin
        cc_nxt = cc_inc;
        if ((tx_count_r != 5'd0) && (cc_inc >= tx_due_r)) begin
          tx_count_nxt = tx_count_r - 5'd1;
          tx_due_nxt   = tx_due_r + 48'(char_time);
          if (tx_count_r == 5'd1) begin
            thre_nxt = 1'b1;
          end
        end
      end
      OP_READ: begin
        case (in_reg_req)
          REG_RBR: begin
            if (dlab) begin
              rd_val = dll_r;
            end else if (rx_count_r != '0) begin
              rd_mem_sel   = 1'b1;
              rx_head_nxt  = rx_head_r + 1'b1;
              rx_count_nxt = rx_count_r - 1'b1;
              rx_moved_nxt = cc_r;
            end
          end
          REG_IER: rd_val = dlab ? dlm_r : {4'd0, ier_r};
          REG_IIR: begin
            if (ier_r[0] && level_cur) begin
              rd_val = fifo_bits | IIR_RX_LEVEL;
            end else if (ier_r[0] && timeout_cur) begin
              rd_val = fifo_bits | IIR_TIMEOUT;
            end else if (ier_r[1] && thre_r) begin
              rd_val   = fifo_bits | IIR_THRE;
              thre_nxt = 1'b0;
            end else begin
              rd_val = fifo_bits | IIR_NONE;
            end
          end
          REG_LCR: rd_val = lcr_r;
          REG_MCR: rd_val = mcr_r;
          REG_LSR: rd_val = {1'b0, tx_count_r == 5'd0, tx_count_r == 5'd0, 4'd0,
                             rx_count_r != '0};
          REG_MSR: rd_val = MSR_VALUE;
          default: rd_val = scr_r;
        endcase
      end
      OP_WRITE: begin
        case (in_reg_req)
          REG_RBR: begin
            if (dlab) begin
              dll_nxt = in_data;
            end else begin
              if (tx_count_r == 5'd0) begin
                tx_due_nxt = cc_r + 48'(char_time);
              end
              if (tx_count_r < TX_FULL) begin
                tx_count_nxt = tx_count_r + 5'd1;
              end
              thre_nxt = 1'b0;
              txv      = 1'b1;
            end
          end
          REG_IER: begin
            if (dlab) begin
              dlm_nxt = in_data;
            end else begin
              if (in_data[1] && !ier_r[1] && (tx_count_r == 5'd0)) begin
                thre_nxt = 1'b1;
              end
              ier_nxt = in_data[3:0];
            end
          end
          REG_IIR: begin
            fcr_nxt = in_data;
            if (in_data[1]) begin
              rx_count_nxt = '0;
              rx_head_nxt  = '0;
            end
            if (in_data[2]) begin
              tx_count_nxt = 5'd0;
            end
          end
          REG_LCR: lcr_nxt = in_data;
          REG_MCR: mcr_nxt = in_data;
          REG_SCR: scr_nxt = in_data;
          default: ;
        endcase
      end
      OP_RX: begin
        if (rx_push) begin
          rx_count_nxt = rx_count_r + 1'b1;
        end
        rx_moved_nxt = cc_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dll_r       <= 8'h00;
      dlm_r       <= 8'h00;
      lcr_r       <= 8'h00;
      mcr_r       <= 8'h00;
      scr_r       <= 8'h00;
      fcr_r       <= 8'h00;
      ier_r       <= 4'h0;
      rx_head_r   <= '0;
      rx_count_r  <= '0;
      tx_count_r  <= 5'd0;
      thre_r      <= 1'b0;
      cc_r        <= 48'd0;
      tx_due_r    <= 48'd0;
      rx_moved_r  <= 48'd0;
      busy_r      <= 2'd3;
      out_valid_r <= 1'b0;
    end else begin
      if (busy_r != 2'd0) begin
        busy_r <= busy_r - 2'd1;
      end else if (in_acc && div_write) begin
        busy_r <= 2'd3;
      end
      if (in_acc) begin
        dll_r       <= dll_nxt;
        dlm_r       <= dlm_nxt;
        lcr_r       <= lcr_nxt;
        mcr_r       <= mcr_nxt;
        scr_r       <= scr_nxt;
        fcr_r       <= fcr_nxt;
        ier_r       <= ier_nxt;
        rx_head_r   <= rx_head_nxt;
        rx_count_r  <= rx_count_nxt;
        tx_count_r  <= tx_count_nxt;
        thre_r      <= thre_nxt;
        cc_r        <= cc_nxt;
        tx_due_r    <= tx_due_nxt;
        rx_moved_r  <= rx_moved_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // receive fifo storage and result register
  always_ff @(posedge clk) begin
    if (in_acc && rx_push) begin
      rx_mem[rx_wr_addr] <= in_data;
    end
    if (in_acc) begin
      rd_mem_r     <= rx_mem[rx_head_r];
      rd_sel_mem_r <= rd_mem_sel;
      rd_reg_r     <= rd_val;
      tx_valid_r   <= txv;
      tx_data_r    <= txv ? in_data : 8'h00;
    end
  end

  // result waits until the character time matches the divisor latch
  assign out_valid     = out_valid_r && (busy_r == 2'd0);
  assign out_read_data = rd_sel_mem_r ? rd_mem_r : rd_reg_r;
  assign out_irq       = (ier_r[0] && (level_cur || timeout_cur)) || (ier_r[1] && thre_r);
  assign out_tx_valid  = tx_valid_r;
  assign out_tx_data   = tx_data_r;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 16550-style UART core: a short directed
// sequence followed by randomised bus, tick and receive traffic, with random
// idling on both channels and a long result hold-off. Every result transfer
// is compared with an item-by-item prediction of the register file, the receive
// FIFO, the transmit timing and the interrupt logic.
// ----------------------------------------------------------------------------
module testbench;
  import u16f_pkg::*;

  localparam int          ITEM_TARGET  = 1700;
  localparam int          QUIET_FROM   = 1450;
  localparam int          HOLD_FROM    = 600;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          RX_SLOTS     = 16;
  localparam logic [63:0] CHAR_SCALE   = 64'd335666720;
  localparam logic [63:0] CHAR_BASE    = 64'd7372800;
  localparam logic [7:0]  LSR_RX_READY = 8'h01;
  localparam logic [7:0]  LSR_TX_IDLE  = 8'h60;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       tx_valid;
    logic [7:0] tx_data;
  } uart_result_t;

  class uart_result_board;
    logic [7:0]   dll, dlm, lcr, mcr, scr, fcr;
    logic [3:0]   ier;
    logic [7:0]   rx_mem [RX_SLOTS];
    logic [3:0]   rx_head;
    logic [4:0]   rx_cnt, tx_cnt;
    logic         thre_pend;
    logic [47:0]  now, tx_due, rx_moved;
    uart_result_t expected_results[$];
    int           errors;

    function new();
      dll = '0; dlm = '0; lcr = '0; mcr = '0; scr = '0; fcr = '0; ier = '0;
      foreach (rx_mem[i]) rx_mem[i] = '0;
      rx_head = '0; rx_cnt = '0; tx_cnt = '0; thre_pend = 1'b0;
      now = '0; tx_due = '0; rx_moved = '0;
      errors = 0;
    endfunction

    function logic [47:0] char_ticks();
      logic [63:0] div;
      logic [63:0] t;
      div = {48'd0, dlm, dll};
      if (div == 64'd0) div = 64'd1;
      t = (div * CHAR_SCALE) / CHAR_BASE;
      return t[47:0];
    endfunction

    function bit level_hit();
      logic [4:0] lvl;
      lvl = fcr[0] ? RX_TRIG[fcr[7:6]] : 5'd1;
      return rx_cnt >= lvl;
    endfunction

    function bit timed_out();
      logic [63:0] deadline;
      deadline = {16'd0, rx_moved} + 64'd4 * {16'd0, char_ticks()};
      return rx_cnt != 0 && {16'd0, now} >= deadline;
    endfunction

    function bit irq_line();
      return (ier[0] && (level_hit() || timed_out())) || (ier[1] && thre_pend);
    endfunction

    function void advance();
      now = now + 48'd1;
      if (tx_cnt != 0 && now >= tx_due) begin
        tx_cnt--;
        tx_due = tx_due + char_ticks();
        if (tx_cnt == 0) thre_pend = 1'b1;
      end
    endfunction

    function void take_rx_byte(logic [7:0] b);
      if (rx_cnt < RX_SLOTS) begin
        rx_mem[rx_head + rx_cnt[3:0]] = b;
        rx_cnt++;
      end
      rx_moved = now;
    endfunction

    function logic [7:0] read_reg(logic [2:0] r);
      logic [7:0] v;
      logic [7:0] fifo_bits;
      v = '0;
      fifo_bits = fcr[0] ? IIR_FIFO_ON : 8'h00;
      case (r)
        REG_RBR: begin
          if (lcr[7]) begin
            v = dll;
          end else if (rx_cnt != 0) begin
            v = rx_mem[rx_head];
            rx_head++;
            rx_cnt--;
            rx_moved = now;
          end
        end
        REG_IER: v = lcr[7] ? dlm : {4'd0, ier};
        REG_IIR: begin
          if (ier[0] && level_hit()) begin
            v = fifo_bits | IIR_RX_LEVEL;
          end else if (ier[0] && timed_out()) begin
            v = fifo_bits | IIR_TIMEOUT;
          end else if (ier[1] && thre_pend) begin
            thre_pend = 1'b0;
            v = fifo_bits | IIR_THRE;
          end else begin
            v = fifo_bits | IIR_NONE;
          end
        end
        REG_LCR: v = lcr;
        REG_MCR: v = mcr;
        REG_LSR: v = (rx_cnt != 0 ? LSR_RX_READY : 8'h00) | (tx_cnt == 0 ? LSR_TX_IDLE : 8'h00);
        REG_MSR: v = MSR_VALUE;
        default: v = scr;
      endcase
      return v;
    endfunction

    function bit write_reg(logic [2:0] r, logic [7:0] v);
      bit sent;
      sent = 1'b0;
      case (r)
        REG_RBR: begin
          if (lcr[7]) begin
            dll = v;
          end else begin
            if (tx_cnt == 0) tx_due = now + char_ticks();
            if (tx_cnt < TX_FULL) tx_cnt++;
            thre_pend = 1'b0;
            sent = 1'b1;
          end
        end
        REG_IER: begin
          if (lcr[7]) begin
            dlm = v;
          end else begin
            if (v[1] && !ier[1] && tx_cnt == 0) thre_pend = 1'b1;
            ier = v[3:0];
          end
        end
        REG_IIR: begin
          fcr = v;
          if (v[1]) begin
            rx_cnt = '0;
            rx_head = '0;
          end
          if (v[2]) tx_cnt = '0;
        end
        REG_LCR: lcr = v;
        REG_MCR: mcr = v;
        REG_SCR: scr = v;
        default: ;
      endcase
      return sent;
    endfunction

    function void note_item(logic [1:0] op, logic [2:0] r, logic [7:0] d);
      uart_result_t res;
      res = '0;
      case (op)
        OP_TICK:  advance();
        OP_READ:  res.read_data = read_reg(r);
        OP_WRITE: res.tx_valid = write_reg(r, d);
        default:  take_rx_byte(d);
      endcase
      res.irq = irq_line();
      if (res.tx_valid) res.tx_data = d;
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [7:0] rd, logic irq, logic txv, logic [7:0] txd);
      uart_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, actual read_data %02h irq %0b tx %0b/%02h",
                 $time, rd, irq, txv, txd);
        return;
      end
      want = expected_results.pop_front();
      if (rd !== want.read_data) begin
        errors++;
        $display("%0t: read_data expected %02h actual %02h", $time, want.read_data, rd);
      end
      if (irq !== want.irq) begin
        errors++;
        $display("%0t: irq expected %0b actual %0b", $time, want.irq, irq);
      end
      if (txv !== want.tx_valid) begin
        errors++;
        $display("%0t: tx_valid expected %0b actual %0b", $time, want.tx_valid, txv);
      end
      if (txd !== want.tx_data) begin
        errors++;
        $display("%0t: tx_data expected %02h actual %02h", $time, want.tx_data, txd);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_op = OP_TICK;
  logic [2:0] in_reg_req = REG_RBR;
  logic [7:0] in_data = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic       out_irq;
  logic       out_tx_valid;
  logic [7:0] out_tx_data;

  uart_result_board board;
  int  items_sent = 0;
  int  cycles = 0;
  bit  gaps_on = 1'b1;
  bit  hold_pending = 1'b0;
  bit  hold_done = 1'b0;

  uart_16550_fifo_core_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_reg_req    (in_reg_req),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_irq       (out_irq),
    .out_tx_valid  (out_tx_valid),
    .out_tx_data   (out_tx_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_read_data, out_irq, out_tx_valid, out_tx_data);
    end
  end

  // result side: random stalls plus one long hold-off on request
  always begin : result_sink
    int gap;
    @(posedge clk);
    if (hold_pending) begin
      hold_pending = 1'b0;
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_ready <= 1'b1;
    end else if (rst_n && gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      out_ready <= 1'b0;
      repeat (gap) @(posedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [2:0] r, input logic [7:0] d);
    int gap;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_reg_req <= r;
    in_data    <= d;
    do @(posedge clk); while (!in_ready);
    board.note_item(op, r, d);
    items_sent++;
  endtask

  task automatic drive_ticks(input int n);
    repeat (n) send_item(OP_TICK, 3'($urandom), 8'($urandom));
  endtask

  task automatic drive_rx_burst(input int n);
    repeat (n) send_item(OP_RX, 3'($urandom), 8'($urandom));
  endtask

  task automatic drain_rx(input int n);
    repeat (n) send_item(OP_READ, REG_RBR, 8'($urandom));
  endtask

  task automatic drive_tx_burst(input int n);
    repeat (n) send_item(OP_WRITE, REG_RBR, 8'($urandom));
  endtask

  task automatic set_divisor(input logic [15:0] div);
    logic [7:0] lc;
    lc = 8'($urandom_range(0, 127));
    send_item(OP_WRITE, REG_LCR, lc | 8'h80);
    send_item(OP_WRITE, REG_RBR, div[7:0]);
    send_item(OP_WRITE, REG_IER, div[15:8]);
    send_item(OP_READ, REG_RBR, 8'($urandom));
    send_item(OP_READ, REG_IER, 8'($urandom));
    send_item(OP_WRITE, REG_LCR, lc);
  endtask

  task automatic drive_noise(input int n);
    logic [1:0] op;
    logic [2:0] r;
    logic [7:0] d;
    repeat (n) begin
      op = 2'($urandom);
      r  = 3'($urandom);
      d  = 8'($urandom);
      // keep the divisor latch closed outside set_divisor
      if (op == OP_WRITE && r == REG_LCR) d[7] = 1'b0;
      send_item(op, r, d);
    end
  endtask

  task automatic drive_control();
    logic [2:0] r;
    logic [7:0] d;
    case ($urandom_range(0, 4))
      0:       r = REG_IIR;
      1:       r = REG_IER;
      2:       r = REG_MCR;
      3:       r = REG_SCR;
      default: r = REG_LCR;
    endcase
    d = 8'($urandom);
    if (r == REG_LCR) d[7] = 1'b0;
    if (r == REG_IIR && $urandom_range(0, 9) < 7) d[0] = 1'b1;
    send_item(OP_WRITE, r, d);
    send_item(OP_READ, 3'($urandom), 8'($urandom));
  endtask

  initial begin : stimulus
    int n;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, read-only offsets, divisor extremes, fifo, thre
    send_item(OP_READ,  REG_IIR, 8'h00);
    send_item(OP_READ,  REG_LSR, 8'h00);
    send_item(OP_READ,  REG_MSR, 8'h00);
    send_item(OP_WRITE, REG_MSR, 8'hFF);
    send_item(OP_WRITE, REG_LSR, 8'hFF);
    send_item(OP_READ,  REG_RBR, 8'h00);
    send_item(OP_WRITE, REG_LCR, 8'h80);
    send_item(OP_WRITE, REG_RBR, 8'hFF);
    send_item(OP_WRITE, REG_IER, 8'hFF);
    send_item(OP_READ,  REG_RBR, 8'h00);
    send_item(OP_READ,  REG_IER, 8'h00);
    send_item(OP_WRITE, REG_RBR, 8'h00);
    send_item(OP_WRITE, REG_IER, 8'h00);
    send_item(OP_WRITE, REG_LCR, 8'h03);
    send_item(OP_WRITE, REG_IIR, 8'hC7);
    send_item(OP_WRITE, REG_IER, 8'h0F);
    send_item(OP_READ,  REG_IIR, 8'h00);
    send_item(OP_WRITE, REG_RBR, 8'hFF);
    send_item(OP_WRITE, REG_RBR, 8'h00);
    send_item(OP_RX,    REG_RBR, 8'hFF);
    send_item(OP_RX,    REG_RBR, 8'h00);
    send_item(OP_TICK,  REG_RBR, 8'h00);
    send_item(OP_READ,  REG_RBR, 8'h00);
    send_item(OP_READ,  REG_RBR, 8'h00);
    send_item(OP_WRITE, REG_SCR, 8'hA5);
    send_item(OP_READ,  REG_SCR, 8'h00);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_FROM) gaps_on = 1'b0;
      if (items_sent >= HOLD_FROM && !hold_done) begin
        hold_done    = 1'b1;
        hold_pending = 1'b1;
        drive_rx_burst(20);
      end
      case ($urandom_range(0, 11))
        0, 1: begin
          n = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
          drive_ticks(n);
        end
        2, 3: drive_rx_burst($urandom_range(1, 20));
        4:    drain_rx($urandom_range(1, 18));
        5:    drive_tx_burst($urandom_range(1, 20));
        6: begin
          if ($urandom_range(0, 5) == 0) begin
            set_divisor(16'($urandom));
            drive_tx_burst(2);
            send_item(OP_READ, REG_LSR, 8'($urandom));
            send_item(OP_WRITE, REG_IIR, 8'($urandom) | 8'h04);
          end
          set_divisor(16'($urandom_range(0, 3)));
        end
        7, 8: drive_control();
        9: repeat ($urandom_range(1, 4)) send_item(OP_READ, ($urandom_range(0, 1) != 0) ? REG_IIR : REG_LSR,
                                                   8'($urandom));
        default: drive_noise($urandom_range(1, 4));
      endcase
    end

    in_valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
src/u16f_pkg.sv
src/u16f_char_time.sv
src/uart_16550_fifo_core_unit.sv
verif/testbench.sv
